>>> hdl/vwbc_pkg.sv
// shared types and constants for the voltage window blink code sequencer
// no dependencies

package vwbc_pkg;

    localparam int VOLT_W   = 16;
    localparam int BLINK_W  = 8;
    localparam int LEVEL_W  = 8;
    localparam int TICK_W   = 8;
    localparam int EIDX_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS  = 3'd5;

    typedef struct packed {
        logic [VOLT_W-1:0]  threshold;
        logic [BLINK_W-1:0] blinks;
    } tbl_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } seq_state_t;

endpackage

>>> hdl/voltage_window_blink_code_sequencer_core.sv
// Voltage window blink code sequencer. A load request or a tick without a sample goes from
// acceptance to the finish state, where its result is registered once the output is free.
// A tick with a sample first scans the table. The position of the first matching entry sets
// how long the scan runs, because the lookup reads the table memory one entry per cycle and
// stops at the first match or at the last entry.
// One request is in work at a time. The next request is accepted while a result still
// waits in the output register. A request whose result is ready while the previous one is
// still waiting stays in its final cycle until that one is taken.
// The table is cleared at reset through per-entry valid bits, so no clearing pass runs.
// depends on vwbc_pkg and vwbc_table

module voltage_window_blink_code_sequencer_core #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [vwbc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [vwbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic                               s_sample_valid,
    input  logic [vwbc_pkg::VOLT_W-1:0]        s_voltage,
    input  logic [vwbc_pkg::EIDX_W-1:0]        s_entry_index,
    input  logic [vwbc_pkg::VOLT_W-1:0]        s_entry_threshold,
    input  logic [vwbc_pkg::BLINK_W-1:0]       s_entry_blinks,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [vwbc_pkg::LEVEL_W-1:0]       m_drive_value,
    output logic                               m_flashing,
    output logic [vwbc_pkg::BLINK_W-1:0]       m_current_blinks
);
    import vwbc_pkg::*;

    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
    localparam int ExtW = 7;

    // configuration registers
    logic [VOLT_W-1:0]  window_width_reg;
    logic [LEVEL_W-1:0] base_level_reg;
    logic [LEVEL_W-1:0] flash_level_reg;
    logic [TICK_W-1:0]  on_ticks_reg;
    logic [TICK_W-1:0]  gap_ticks_reg;
    logic [TICK_W-1:0]  pause_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_width_reg <= '0;
            base_level_reg   <= '0;
            flash_level_reg  <= '1;
            on_ticks_reg     <= '0;
            gap_ticks_reg    <= '0;
            pause_ticks_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_WINDOW_WIDTH: window_width_reg <= cfg_wdata;
                CFG_BASE_LEVEL:   base_level_reg   <= cfg_wdata[LEVEL_W-1:0];
                CFG_FLASH_LEVEL:  flash_level_reg  <= cfg_wdata[LEVEL_W-1:0];
                CFG_ON_TICKS:     on_ticks_reg     <= cfg_wdata[TICK_W-1:0];
                CFG_GAP_TICKS:    gap_ticks_reg    <= cfg_wdata[TICK_W-1:0];
                CFG_PAUSE_TICKS:  pause_ticks_reg  <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // captured request
    logic               op_reg;
    logic               sample_reg;
    logic [VOLT_W-1:0]  voltage_reg;
    logic [EIDX_W-1:0]  eidx_reg;
    tbl_entry_t         entry_reg;

    // sequencer and scan state
    seq_state_t         state_reg, state_next;
    logic [IdxW-1:0]    scan_idx_reg;
    logic [IdxW-1:0]    chk_idx_reg;
    logic               chk_valid_reg;
    logic [BLINK_W-1:0] lu_blinks_reg;

    // pattern state
    logic [BLINK_W-1:0] blink_total_reg, blink_total_next;
    logic [BLINK_W-1:0] blink_pos_reg, blink_pos_next;
    logic               flash_active_reg, flash_active_next;
    logic [TICK_W-1:0]  ticks_left_reg, ticks_left_next;
    logic               level_flash_reg, level_flash_next;

    // output register
    logic               m_valid_reg;
    logic [LEVEL_W-1:0] drive_reg;
    logic               flashing_reg;
    logic [BLINK_W-1:0] cur_blinks_reg;

    logic               accept;
    logic               out_free;
    logic               fin_load;
    logic               tbl_we;
    logic [IdxW-1:0]    rd_addr;
    tbl_entry_t         rd_data;
    logic [ExtW-1:0]    eidx_ext;
    logic               idx_ok;
    logic [VOLT_W-1:0]  span;
    logic               match;
    logic               scan_done;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign eidx_ext = ExtW'(eidx_reg);
    assign idx_ok   = eidx_ext < ExtW'(TABLE_ENTRIES);

    vwbc_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_we),
        .wr_addr (IdxW'(eidx_ext)),
        .wr_data (entry_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // window check: v <= top and top - v <= width
    assign span      = rd_data.threshold - voltage_reg;
    assign match     = (voltage_reg <= rd_data.threshold) && (span <= window_width_reg);
    assign scan_done = chk_valid_reg && (match || (chk_idx_reg == LastIdx));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == OP_TICK && s_sample_valid) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        fin_load = 1'b0;
        rd_addr  = scan_idx_reg;
        unique case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_SCAN: rd_addr  = scan_idx_reg;
            ST_FIN:  fin_load = out_free;
            default: ;
        endcase
    end

    // table writes happen only while no scan runs, so reads never overlap them
    assign tbl_we = fin_load && (op_reg == OP_LOAD) && idx_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN) begin
                chk_valid_reg <= !scan_done;
            end else begin
                chk_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg           <= s_opcode;
            sample_reg       <= s_sample_valid;
            voltage_reg      <= s_voltage;
            eidx_reg         <= s_entry_index;
            entry_reg.threshold <= s_entry_threshold;
            entry_reg.blinks    <= s_entry_blinks;
            scan_idx_reg     <= '0;
        end else if (state_reg == ST_SCAN && scan_idx_reg != LastIdx) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        chk_idx_reg <= scan_idx_reg;
        if (state_reg == ST_SCAN && scan_done) begin
            lu_blinks_reg <= match ? rd_data.blinks : '0;
        end
    end

    // on a tick: burst restart when a sample changes the count, then one pattern step
    always_comb begin
        blink_total_next  = blink_total_reg;
        blink_pos_next    = blink_pos_reg;
        flash_active_next = flash_active_reg;
        ticks_left_next   = ticks_left_reg;
        level_flash_next  = level_flash_reg;
        if (op_reg == OP_TICK) begin
            if (sample_reg && lu_blinks_reg != blink_total_reg) begin
                blink_total_next = lu_blinks_reg;
                blink_pos_next   = '0;
                if (lu_blinks_reg == '0) begin
                    flash_active_next = 1'b0;
                    ticks_left_next   = '0;
                    level_flash_next  = 1'b0;
                end else begin
                    flash_active_next = 1'b1;
                    ticks_left_next   = on_ticks_reg;
                    level_flash_next  = 1'b1;
                end
            end
            priority if (blink_total_next == '0) begin
                level_flash_next = 1'b0;
            end else if (ticks_left_next != '0) begin
                ticks_left_next = ticks_left_next - 1'b1;
            end else if (flash_active_next) begin
                flash_active_next = 1'b0;
                blink_pos_next    = blink_pos_next + 1'b1;
                level_flash_next  = 1'b0;
                ticks_left_next   = (blink_pos_next < blink_total_next) ?
                                    gap_ticks_reg : pause_ticks_reg;
            end else begin
                if (blink_pos_next >= blink_total_next) begin
                    blink_pos_next = '0;
                end
                flash_active_next = 1'b1;
                ticks_left_next   = on_ticks_reg;
                level_flash_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_total_reg  <= '0;
            blink_pos_reg    <= '0;
            flash_active_reg <= 1'b0;
            ticks_left_reg   <= '0;
            level_flash_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (fin_load) begin
                blink_total_reg  <= blink_total_next;
                blink_pos_reg    <= blink_pos_next;
                flash_active_reg <= flash_active_next;
                ticks_left_reg   <= ticks_left_next;
                level_flash_reg  <= level_flash_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            drive_reg      <= level_flash_next ? flash_level_reg : base_level_reg;
            flashing_reg   <= level_flash_next;
            cur_blinks_reg <= blink_total_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_drive_value    = drive_reg;
    assign m_flashing       = flashing_reg;
    assign m_current_blinks = cur_blinks_reg;

endmodule

>>> hdl/vwbc_table.sv
// threshold/blink table: one synchronous memory with registered read
// per-entry valid bits cleared at reset, depends on vwbc_pkg

module vwbc_table #(
    parameter int ENTRIES = 8,
    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [IdxW-1:0]     wr_addr,
    input  vwbc_pkg::tbl_entry_t wr_data,
    input  logic [IdxW-1:0]     rd_addr,
    output vwbc_pkg::tbl_entry_t rd_data
);
    import vwbc_pkg::*;

    tbl_entry_t           mem [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    tbl_entry_t           rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // never-written entries read as the cleared value
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for voltage_window_blink_code_sequencer_core: directed table, then
// randomized phases under several register settings, checked against an in-bench predictor
// depends on vwbc_pkg and the core rtl

module tb_top;
    import vwbc_pkg::*;

    localparam int ENTRIES     = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 47;
    localparam int STALL_LIMIT = 4000;
    localparam int N_DIRECTED  = 24;

    typedef struct packed {
        logic               op;
        logic               smp;
        logic [VOLT_W-1:0]  volt;
        logic [EIDX_W-1:0]  idx;
        logic [VOLT_W-1:0]  thr;
        logic [BLINK_W-1:0] cnt;
    } blink_req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] drive;
        logic               lit;
        logic [BLINK_W-1:0] count;
    } drive_state_t;

    typedef struct packed {
        blink_req_t   req;
        logic         known;
        drive_state_t want;
    } step_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_opcode = OP_TICK;
    logic                  s_sample_valid = 1'b0;
    logic [VOLT_W-1:0]     s_voltage = '0;
    logic [EIDX_W-1:0]     s_entry_index = '0;
    logic [VOLT_W-1:0]     s_entry_threshold = '0;
    logic [BLINK_W-1:0]    s_entry_blinks = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LEVEL_W-1:0]    m_drive_value;
    logic                  m_flashing;
    logic [BLINK_W-1:0]    m_current_blinks;

    voltage_window_blink_code_sequencer_core #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_sample_valid   (s_sample_valid),
        .s_voltage        (s_voltage),
        .s_entry_index    (s_entry_index),
        .s_entry_threshold(s_entry_threshold),
        .s_entry_blinks   (s_entry_blinks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_value    (m_drive_value),
        .m_flashing       (m_flashing),
        .m_current_blinks (m_current_blinks)
    );

    always #1 aclk = ~aclk;

    // predictor state and register copy
    tbl_entry_t          entry_tbl [ENTRIES] = '{default: '0};
    logic [BLINK_W-1:0]  burst_count = '0;
    logic [BLINK_W-1:0]  blink_pos = '0;
    logic [TICK_W-1:0]   hold_left = '0;
    logic                flash_on = 1'b0;
    logic                lit = 1'b0;
    logic [VOLT_W-1:0]   win = '0;
    logic [LEVEL_W-1:0]  base_lvl = '0;
    logic [LEVEL_W-1:0]  flash_lvl = 8'hff;
    logic [TICK_W-1:0]   on_len = '0;
    logic [TICK_W-1:0]   gap_len = '0;
    logic [TICK_W-1:0]   pause_len = '0;

    drive_state_t expected_drive [$];
    int mismatches = 0;
    int n_checked = 0;
    int n_loads = 0;
    int n_sampled = 0;
    int n_ticks = 0;
    int n_settings = 0;
    int idle_cycles = 0;

    step_row_t directed_rows [N_DIRECTED];

    function automatic drive_state_t predict_drive(input blink_req_t r);
        logic [BLINK_W-1:0] n;
        logic [VOLT_W-1:0]  top;
        logic [VOLT_W-1:0]  bottom;
        drive_state_t       d;
        if (r.op == OP_LOAD) begin
            if (r.idx < ENTRIES) begin
                entry_tbl[r.idx].threshold = r.thr;
                entry_tbl[r.idx].blinks = r.cnt;
            end
        end else begin
            if (r.smp) begin
                n = '0;
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    top = entry_tbl[i].threshold;
                    bottom = (top > win) ? top - win : '0;
                    if (r.volt <= top && r.volt >= bottom) begin
                        n = entry_tbl[i].blinks;
                    end
                end
                if (n != burst_count) begin
                    // new burst
                    burst_count = n;
                    blink_pos = '0;
                    flash_on = (n != 0);
                    hold_left = (n != 0) ? on_len : '0;
                    lit = (n != 0);
                end
            end
            // advance the blink pattern
            if (burst_count == 0) begin
                lit = 1'b0;
            end else if (hold_left != 0) begin
                hold_left = hold_left - 1'b1;
            end else if (flash_on) begin
                flash_on = 1'b0;
                blink_pos = blink_pos + 1'b1;
                lit = 1'b0;
                hold_left = (blink_pos < burst_count) ? gap_len : pause_len;
            end else begin
                if (blink_pos >= burst_count) begin
                    blink_pos = '0;
                end
                flash_on = 1'b1;
                hold_left = on_len;
                lit = 1'b1;
            end
        end
        d.drive = lit ? flash_lvl : base_lvl;
        d.lit = lit;
        d.count = burst_count;
        return d;
    endfunction

    task automatic send_request(input blink_req_t req, input drive_state_t want,
                                input logic known, input int gap);
        drive_state_t got;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= req.op;
        s_sample_valid <= req.smp;
        s_voltage <= req.volt;
        s_entry_index <= req.idx;
        s_entry_threshold <= req.thr;
        s_entry_blinks <= req.cnt;
        do @(posedge aclk); while (!s_ready);
        got = predict_drive(req);
        expected_drive.push_back(known ? want : got);
        if (req.op == OP_LOAD) n_loads++;
        else if (req.smp) n_sampled++;
        else n_ticks++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            CFG_WINDOW_WIDTH: win = data;
            CFG_BASE_LEVEL:   base_lvl = data[LEVEL_W-1:0];
            CFG_FLASH_LEVEL:  flash_lvl = data[LEVEL_W-1:0];
            CFG_ON_TICKS:     on_len = data[TICK_W-1:0];
            CFG_GAP_TICKS:    gap_len = data[TICK_W-1:0];
            CFG_PAUSE_TICKS:  pause_len = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [TICK_W-1:0] pick_ticks();
        return ($urandom_range(0, 7) == 0) ? TICK_W'($urandom_range(0, 255))
                                           : TICK_W'($urandom_range(0, 3));
    endfunction

    // result side: random stalls, occasional stretches of no stalls
    initial begin
        int stall;
        int calm_left;
        drive_state_t want;
        calm_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm_left > 0) begin
                calm_left--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 11);
                if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            n_checked++;
            if (expected_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: drive=%0h flashing=%0b blinks=%0d",
                             m_drive_value, m_flashing, m_current_blinks);
            end else begin
                want = expected_drive.pop_front();
                if (m_drive_value !== want.drive || m_flashing !== want.lit ||
                    m_current_blinks !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: drive exp %0h got %0h, flashing exp %0b got %0b, %s%0d got %0d",
                                 want.drive, m_drive_value, want.lit, m_flashing,
                                 "blinks exp ", want.count, m_current_blinks);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout waiting on a handshake");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        blink_req_t   req;
        drive_state_t none;
        int           k;
        int           off;
        int           sel;
        logic         calm;

        none = '0;
        directed_rows = '{
            // reset state, empty table
            '{'{OP_TICK, 1'b0, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0, 8'h00}},
            '{'{OP_TICK, 1'b1, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0, 8'h00}},
            '{'{OP_TICK, 1'b1, 16'hffff, 3'd0, 16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0, 8'h00}},
            '{'{OP_LOAD, 1'b0, 16'h0000, 3'd0, 16'hffff, 8'hff}, 1'b1, '{8'h00, 1'b0, 8'h00}},
            '{'{OP_LOAD, 1'b1, 16'hffff, 3'd7, 16'h0000, 8'h01}, 1'b1, '{8'h00, 1'b0, 8'h00}},
            // top threshold, max count
            '{'{OP_TICK, 1'b1, 16'hffff, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_TICK, 1'b0, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_TICK, 1'b0, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_TICK, 1'b0, 16'hffff, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            // load mid-burst leaves the pattern alone
            '{'{OP_LOAD, 1'b0, 16'h0000, 3'd1, 16'h1000, 8'h02}, 1'b0, none},
            '{'{OP_LOAD, 1'b0, 16'h0000, 3'd2, 16'h2000, 8'h03}, 1'b0, none},
            '{'{OP_LOAD, 1'b0, 16'h0000, 3'd3, 16'h4000, 8'h04}, 1'b0, none},
            '{'{OP_LOAD, 1'b0, 16'h0000, 3'd4, 16'h8000, 8'h05}, 1'b0, none},
            '{'{OP_LOAD, 1'b0, 16'h0000, 3'd5, 16'haaaa, 8'h06}, 1'b0, none},
            '{'{OP_LOAD, 1'b0, 16'h0000, 3'd6, 16'h5555, 8'h07}, 1'b0, none},
            // count change restarts the burst
            '{'{OP_TICK, 1'b1, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_TICK, 1'b0, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_TICK, 1'b0, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_TICK, 1'b1, 16'h5555, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            // no match drops to zero count
            '{'{OP_TICK, 1'b1, 16'h0001, 3'd0, 16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0, 8'h00}},
            '{'{OP_TICK, 1'b1, 16'h8000, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_TICK, 1'b0, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_LOAD, 1'b0, 16'h0000, 3'd0, 16'h0000, 8'h00}, 1'b0, none},
            '{'{OP_TICK, 1'b1, 16'hffff, 3'd0, 16'h0000, 8'h00}, 1'b1, '{8'h00, 1'b0, 8'h00}}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        n_settings = 1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].want,
                         directed_rows[i].known, $urandom_range(0, 11));
        end

        for (int p = 0; p < PHASES; p++) begin
            // registers change only with nothing in flight
            drain_results();
            case (p)
                0: begin
                    write_reg(CFG_WINDOW_WIDTH, 16'hffff);
                    write_reg(CFG_BASE_LEVEL, 16'h00ff);
                    write_reg(CFG_FLASH_LEVEL, 16'h0000);
                    write_reg(CFG_ON_TICKS, 16'h0000);
                    write_reg(CFG_GAP_TICKS, 16'h0000);
                    write_reg(CFG_PAUSE_TICKS, 16'h0000);
                end
                1: begin
                    write_reg(CFG_WINDOW_WIDTH, 16'h0000);
                    write_reg(CFG_BASE_LEVEL, 16'h0000);
                    write_reg(CFG_FLASH_LEVEL, 16'h00ff);
                    write_reg(CFG_ON_TICKS, 16'h00ff);
                    write_reg(CFG_GAP_TICKS, 16'h00ff);
                    write_reg(CFG_PAUSE_TICKS, 16'h00ff);
                end
                default: begin
                    sel = $urandom_range(0, 2);
                    write_reg(CFG_WINDOW_WIDTH, (sel == 0) ? 16'($urandom) :
                                                (sel == 1) ? 16'($urandom_range(0, 255)) :
                                                16'($urandom_range(0, 4095)));
                    write_reg(CFG_BASE_LEVEL, 16'($urandom_range(0, 255)));
                    write_reg(CFG_FLASH_LEVEL, 16'($urandom_range(0, 255)));
                    write_reg(CFG_ON_TICKS, 16'(pick_ticks()));
                    write_reg(CFG_GAP_TICKS, 16'(pick_ticks()));
                    write_reg(CFG_PAUSE_TICKS, 16'(pick_ticks()));
                end
            endcase
            cfg_we <= 1'b0;
            n_settings++;
            calm = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req.op = OP_TICK;
                req.smp = 1'($urandom_range(0, 1));
                req.volt = 16'($urandom);
                req.idx = EIDX_W'($urandom);
                req.thr = 16'($urandom);
                req.cnt = 8'($urandom);
                sel = $urandom_range(0, 9);
                if (sel < 2 || n < 3) begin
                    req.op = OP_LOAD;
                    case ($urandom_range(0, 5))
                        0:       req.cnt = 8'h00;
                        1:       req.cnt = 8'hff;
                        2:       ;
                        default: req.cnt = 8'($urandom_range(1, 5));
                    endcase
                end else if (sel < 6) begin
                    req.smp = 1'b1;
                    k = $urandom_range(0, ENTRIES - 1);
                    case ($urandom_range(0, 3))
                        0: ;
                        1: req.volt = entry_tbl[k].threshold + 1'b1;
                        default: begin
                            off = (win == 0) ? 0 : $urandom_range(0, int'(win));
                            req.volt = (int'(entry_tbl[k].threshold) >= off)
                                       ? entry_tbl[k].threshold - 16'(off) : '0;
                        end
                    endcase
                end else begin
                    req.smp = 1'b0;
                end
                send_request(req, none, 1'b0, calm ? 0 : $urandom_range(0, 11));
            end
        end

        drain_results();
        repeat (16) @(posedge aclk);

        $display("covered %0d loads, %0d sampled ticks, %0d plain ticks under %0d settings",
                 n_loads, n_sampled, n_ticks, n_settings);
        $display("%0d results checked, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/vwbc_pkg.sv
hdl/vwbc_table.sv
hdl/voltage_window_blink_code_sequencer_core.sv
dv/tb_top.sv
